// ===== rtl/mm64_pkg.sv =====
// Shared constants, types and helpers for the MurmurHash64A stream hash.
`default_nettype none
package mm64_pkg;

  localparam logic [63:0] MIX_M       = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_R       = 47;
  localparam logic [63:0] SEED_RESET  = 64'hdeadbeefdeadbeef;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  // How the back end has to treat a word
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,   // last word, no bytes: straight to the finaliser
    KIND_PART = 2'd1,   // last word, 1..7 bytes: masked xor, then multiply
    KIND_FULL = 2'd2    // full mix and fold
  } kind_t;

  typedef struct packed {
    logic        first;
    logic        last;
    kind_t       kind;
    logic [31:0] length;
    logic [63:0] word;
  } entry_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    case (nb)
      4'd1:    m = 64'h0000_0000_0000_00ff;
      4'd2:    m = 64'h0000_0000_0000_ffff;
      4'd3:    m = 64'h0000_0000_00ff_ffff;
      4'd4:    m = 64'h0000_0000_ffff_ffff;
      4'd5:    m = 64'h0000_00ff_ffff_ffff;
      4'd6:    m = 64'h0000_ffff_ffff_ffff;
      4'd7:    m = 64'h00ff_ffff_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> MIX_R);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mm64_front.sv =====
// Front end: unpacks input transactions and classifies each word for the back end.
`default_nettype none
module mm64_front import mm64_pkg::*; (
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         in_tlast,
  input  wire logic         q_full,
  output logic              q_push,
  output entry_t            q_entry
);

  logic [63:0] word;
  logic [3:0]  vbytes;
  logic [3:0]  nb;
  kind_t       kind;

  assign word      = in_tdata[63:0];
  assign vbytes    = in_tdata[67:64];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    nb = (vbytes > 4'd8) ? 4'd8 : vbytes;
    if (!in_tlast || nb == 4'd8) begin
      kind = KIND_FULL;
    end else if (nb == 4'd0) begin
      kind = KIND_NONE;
    end else begin
      kind = KIND_PART;
    end
    q_entry.first  = in_tuser;
    q_entry.last   = in_tlast;
    q_entry.kind   = kind;
    q_entry.length = in_tdata[99:68];
    q_entry.word   = (kind == KIND_PART) ? (word & byte_mask(nb)) : word;
  end

endmodule
`default_nettype wire

// ===== rtl/mm64_queue.sv =====
// Short queue of classified words between front and back end.
`default_nettype none
module mm64_queue import mm64_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output entry_t      pop_data,
  output logic        valid
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mm64_mul.sv =====
// Low 64 bits of a * M from three 32x32 partial products on one shared multiplier.
`default_nettype none
module mm64_mul import mm64_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  output logic             done,
  output logic [63:0]      result
);

  logic [63:0] a_r;
  logic [1:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod_nxt;

  // lo*lo full width, then the two cross terms of which only the low half counts
  always_comb begin
    case (cnt_r)
      2'd1:    begin op_a = a_r[63:32]; op_b = MIX_M[31:0];  end
      2'd2:    begin op_a = a_r[31:0];  op_b = MIX_M[63:32]; end
      default: begin op_a = a_r[31:0];  op_b = MIX_M[31:0];  end
    endcase
    prod_nxt = {32'd0, op_a} * {32'd0, op_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        cnt_r  <= cnt_r + 1'b1;
        prod_r <= prod_nxt;
        case (cnt_r)
          2'd0:    acc_r <= acc_r;
          2'd1:    acc_r <= prod_r;
          default: acc_r <= acc_r + {prod_r[31:0], 32'd0};
        endcase
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule
`default_nettype wire

// ===== rtl/mm64_back.sv =====
// Back end: sequences seeding, word mixing, folding and finalising on the multiplier.
`default_nettype none
module mm64_back import mm64_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        q_valid,
  input  wire entry_t      q_entry,
  output logic             q_pop,
  output logic             mul_start,
  output logic [63:0]      mul_a,
  input  wire logic        mul_done,
  input  wire logic [63:0] mul_res,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEED, ST_DISP, ST_MIX1, ST_MIX2, ST_FOLD, ST_FIN, ST_OUT
  } state_t;

  state_t      st_r;
  entry_t      cur_r;
  logic [63:0] h_r;
  logic [63:0] seed_r;
  logic        mul_start_r;
  logic [63:0] mul_a_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  assign q_pop      = (st_r == ST_IDLE) && q_valid;
  assign mul_start  = mul_start_r;
  assign mul_a      = mul_a_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      h_r         <= '0;
      seed_r      <= SEED_RESET;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      // in ST_OUT the output register is reloaded below instead
      if (out_valid_r && out_tready && st_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_r <= q_entry;
            if (q_entry.first) begin
              mul_start_r <= 1'b1;
              mul_a_r     <= {32'd0, q_entry.length};
              st_r        <= ST_SEED;
            end else begin
              st_r <= ST_DISP;
            end
          end
        end
        ST_SEED: begin
          if (mul_done) begin
            h_r  <= seed_r ^ mul_res;
            st_r <= ST_DISP;
          end
        end
        ST_DISP: begin
          mul_start_r <= 1'b1;
          case (cur_r.kind)
            KIND_FULL: begin
              mul_a_r <= cur_r.word;
              st_r    <= ST_MIX1;
            end
            KIND_PART: begin
              mul_a_r <= h_r ^ cur_r.word;
              st_r    <= ST_FOLD;
            end
            default: begin
              mul_a_r <= xorshift(h_r);
              st_r    <= ST_FIN;
            end
          endcase
        end
        ST_MIX1: begin
          if (mul_done) begin
            mul_start_r <= 1'b1;
            mul_a_r     <= xorshift(mul_res);
            st_r        <= ST_MIX2;
          end
        end
        ST_MIX2: begin
          if (mul_done) begin
            mul_start_r <= 1'b1;
            mul_a_r     <= h_r ^ mul_res;
            st_r        <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (mul_done) begin
            if (cur_r.last) begin
              mul_start_r <= 1'b1;
              mul_a_r     <= xorshift(mul_res);
              st_r        <= ST_FIN;
            end else begin
              h_r  <= mul_res;
              st_r <= ST_IDLE;
            end
          end
        end
        ST_FIN: begin
          if (mul_done) begin
            h_r  <= xorshift(mul_res);
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // wait for the output register to drain, then start the next message from zero
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= h_r;
            h_r         <= '0;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/murmur64a_stream_hash_unit.sv =====
// Top level of the MurmurHash64A stream hash unit.
//
//  channel  direction  tdata / tuser / tlast
//  in_      slave      tdata: data_word, valid_bytes, message_length; tuser: first_word;
//                      tlast: last_word
//  out_     master     tdata: hash_value
//  cfg_     write      cfg_wr_data: seed
//
// Every 64-bit multiply by M runs as three 32x32 partial products on one shared
// multiplier; a word needs one to five of them (seed on a first word, two for the
// mix, one for the fold, one for the finaliser), plus the dispatch states ST_IDLE
// and ST_DISP. A two-entry queue lets input be taken while the back end works; the
// output register holds a finished hash until it is taken.
// rst_n is synchronous; it clears the queue, the running hash and the seed (to its
// default).
`default_nettype none
module murmur64a_stream_hash_unit import mm64_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // data_word[63:0], valid_bytes[67:64],
                                        // message_length[99:68], zero pad
  input  wire logic         in_tuser,   // first_word
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // hash_value[63:0]
  input  wire logic         cfg_wr_en,
  input  wire logic [63:0]  cfg_wr_data
);

  logic        q_full;
  logic        q_push;
  entry_t      q_in;
  logic        q_pop;
  entry_t      q_out;
  logic        q_valid;
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_res;

  mm64_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  mm64_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .valid     (q_valid)
  );

  mm64_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .done   (mul_done),
    .result (mul_res)
  );

  mm64_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_entry     (q_out),
    .q_pop       (q_pop),
    .mul_start   (mul_start),
    .mul_a       (mul_a),
    .mul_done    (mul_done),
    .mul_res     (mul_res),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

// ===== rtl/mm64_checker.sv =====
// Port-level checks for the hash unit, bound to the top level.
`default_nettype none
module mm64_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata
);

  // reset leaves no result pending
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // reset empties the queue, so input is taken straight away
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  // the queue only fills through an accepted transaction
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("input refused without a transaction");

endmodule

bind murmur64a_stream_hash_unit mm64_checker u_mm64_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
